// ===== design/sha1_pkg.sv =====
// Shared types, constants and control structs for the SHA-1 byte stream hasher.
`default_nettype none

package sha1_pkg;

  localparam logic       FUNC_ABSORB = 1'b0;
  localparam logic       FUNC_FINISH = 1'b1;

  localparam logic [5:0] LEN_POS     = 6'd56;  // first byte of the length field
  localparam logic [5:0] LAST_POS    = 6'd63;  // last byte of a block
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [4:0] SUB_LAST    = 5'd19;  // last round of a 20-round stage
  localparam logic [1:0] STAGE_LAST  = 2'd3;

  typedef logic [0:4][31:0] chain_t;

  localparam chain_t H_INIT = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [0:3][31:0] K_ROUND = {
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
    logic        length_overflow;
  } out_t;

  // Controls for the message window.
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       step;
  } sched_ctl_t;

  // Controls for the round unit and chaining registers.
  typedef struct packed {
    logic       start;
    logic       step;
    logic [1:0] stage;
    logic       fold;
    logic       restart;
  } round_ctl_t;

endpackage

`default_nettype wire

// ===== design/sha1_sched.sv =====
// Message window: 64-byte block shift register that also expands the schedule.
`default_nettype none

module sha1_sched import sha1_pkg::*; (
  input  logic        clk,
  input  sched_ctl_t  ctl,
  output logic [31:0] w
);

  // Word i of the window sits at bits [511-32*i -: 32]; word 0 is W[t].
  logic [511:0] win;
  logic [31:0]  w_mix;
  logic [31:0]  w_new;

  assign w     = win[511 -: 32];
  assign w_mix = win[511 -: 32] ^ win[447 -: 32] ^ win[255 -: 32] ^ win[95 -: 32];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      win <= {win[503:0], ctl.push_byte};
    end else if (ctl.step) begin
      win <= {win[479:0], w_new};
    end
  end

endmodule

`default_nettype wire

// ===== design/sha1_round.sv =====
// Shared round unit: working variables, one round per cycle, chaining value fold.
`default_nettype none

module sha1_round import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  round_ctl_t  ctl,
  input  logic [31:0] w,
  output chain_t      chain
);

  logic [31:0] a, b, c, d, e;
  logic [31:0] f;
  logic [31:0] t;

  always_comb begin
    case (ctl.stage)
      2'd0:    f = (b & c) | (~b & d);
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
  end

  assign t = {a[26:0], a[31:27]} + f + e + K_ROUND[ctl.stage] + w;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctl.step) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= H_INIT;
    end else if (ctl.restart) begin
      chain <= H_INIT;
    end else if (ctl.fold) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

endmodule

`default_nettype wire

// ===== design/sha1_byte_stream_hasher.sv =====
// Top level of the SHA-1 byte stream hasher: sequencer, counters, output register.
`default_nettype none

//  channel | signals                          | moves
//  --------+----------------------------------+-------------------------------------------
//  in      | in_valid, in_ready, in_item      | one byte to absorb, or a finish command
//  out     | out_valid, out_ready, out_item   | five digest words and the overflow flag
//
//  in_ready is high only while the sequencer idles. An absorbed byte keeps it idle unless
//  it fills a block: then the rounds and the fold run before in_ready returns.
//  A finish is accepted from idle, pushes the padding one byte per cycle, compresses one or
//  two blocks (rounds and fold each) and then loads the output register.
//  A held digest does not block absorbing; a finish waits at the end only while the
//  previous digest is untaken. rst is synchronous and restores chaining value, count, flag.

module sha1_byte_stream_hasher import sha1_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_item
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [5:0]  pos;          // next byte slot in the block
  logic [60:0] byte_cnt;     // message length in bytes; bit length is byte_cnt * 8
  logic        ovf;
  logic        finishing;    // padding in progress for the current message
  logic        first;        // next pad byte is the 0x80 marker
  logic        extra;        // length field does not fit, one more block follows
  logic        final_blk;    // block now compressing carries the length
  logic [1:0]  stage;
  logic [4:0]  sub;

  logic        in_fire;
  logic        absorb;
  logic        finish;
  logic        pad_push;
  logic        push;
  logic [7:0]  push_byte;
  logic [7:0]  pad_byte;
  logic        blk_full;
  logic        round_last;
  logic        out_free;
  logic        out_load;
  logic [61:0] cnt_inc;
  logic [63:0] len_shift;
  logic [31:0] w;
  chain_t      chain;
  sched_ctl_t  sched_ctl;
  round_ctl_t  round_ctl;

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign absorb     = in_fire && (in_item.func == FUNC_ABSORB);
  assign finish     = in_fire && (in_item.func == FUNC_FINISH);
  assign pad_push   = (state == ST_PAD);
  assign push       = absorb || pad_push;
  assign blk_full   = push && (pos == LAST_POS);
  assign round_last = (stage == STAGE_LAST) && (sub == SUB_LAST);
  assign out_free   = !out_valid || out_ready;
  assign out_load   = (state == ST_DONE) && out_free;
  assign cnt_inc    = {1'b0, byte_cnt} + 62'd1;

  // Big-endian bit length; byte k of the length field lands at pos 56+k.
  assign len_shift  = {byte_cnt, 3'b000} << {pos[2:0], 3'b000};

  always_comb begin
    if (first) begin
      pad_byte = PAD_BYTE;
    end else if (!extra && (pos >= LEN_POS)) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign push_byte = absorb ? in_item.data_byte : pad_byte;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (finish) begin
          state_next = ST_PAD;
        end else if (blk_full) begin
          state_next = ST_ROUND;
        end
      end
      ST_PAD: begin
        if (blk_full) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (final_blk) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= 6'd0;
      byte_cnt  <= 61'd0;
      ovf       <= 1'b0;
      finishing <= 1'b0;
      first     <= 1'b0;
      extra     <= 1'b0;
      final_blk <= 1'b0;
      stage     <= 2'd0;
      sub       <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (push) begin
        pos <= pos + 6'd1;
      end

      // Carry out of the byte count means the bit count reached 2^64.
      if (absorb) begin
        byte_cnt <= cnt_inc[60:0];
        if (cnt_inc[61]) begin
          ovf <= 1'b1;
        end
      end

      if (finish) begin
        finishing <= 1'b1;
        first     <= 1'b1;
        extra     <= (pos >= LEN_POS);
      end

      if (pad_push) begin
        first <= 1'b0;
        if (pos == LAST_POS) begin
          final_blk <= !extra;
          extra     <= 1'b0;
        end
      end

      if (state == ST_ROUND) begin
        if (sub == SUB_LAST) begin
          sub   <= 5'd0;
          stage <= stage + 2'd1;
        end else begin
          sub <= sub + 5'd1;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
        byte_cnt  <= 61'd0;
        ovf       <= 1'b0;
        finishing <= 1'b0;
        final_blk <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.digest_word0    <= chain[0];
      out_item.digest_word1    <= chain[1];
      out_item.digest_word2    <= chain[2];
      out_item.digest_word3    <= chain[3];
      out_item.digest_word4    <= chain[4];
      out_item.length_overflow <= ovf;
    end
  end

  assign sched_ctl.push      = push;
  assign sched_ctl.push_byte = push_byte;
  assign sched_ctl.step      = (state == ST_ROUND);

  assign round_ctl.start   = blk_full;
  assign round_ctl.step    = (state == ST_ROUND);
  assign round_ctl.stage   = stage;
  assign round_ctl.fold    = (state == ST_FOLD);
  assign round_ctl.restart = out_load;

  sha1_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .w   (w)
  );

  sha1_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl   (round_ctl),
    .w     (w),
    .chain (chain)
  );

endmodule

`default_nettype wire

// ===== design/sha1_chk.sv =====
// Port-level checker for the SHA-1 byte stream hasher, bound to the top level.
`default_nettype none

module sha1_chk import sha1_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_item,
  input logic out_valid,
  input logic out_ready,
  input out_t out_item
);

  // A held digest stays put until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("digest changed or dropped while stalled");

  // A finish always needs padding and at least one compression.
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_item.func == FUNC_FINISH)
      |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("ready too soon after a finish");

  // A digest appears only out of the busy finishing sequence.
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("digest appeared while idle");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sha1_byte_stream_hasher sha1_chk u_chk (.*);

`default_nettype wire
